/* rtl/core/asm_comment_stripper_defines.svh */
// ============================================================================
// asm_comment_stripper_defines.svh
// Assertion macros used by the comment stripper checker.
// ============================================================================
`ifndef ASM_COMMENT_STRIPPER_DEFINES_SVH
`define ASM_COMMENT_STRIPPER_DEFINES_SVH

// Clocked assertion, disabled while reset is asserted
`define ACS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked assertion that also holds through reset
`define ACS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/core/acs_pkg.sv */
// ============================================================================
// acs_pkg
// Types, character codes and the per-byte decision function of the
// assembler comment stripper.
// ============================================================================
`timescale 1ns / 1ps

package acs_pkg;

    // Character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_AT     = 8'h40;

    // Reset value of the comment character register
    localparam logic [7:0] LINE_CHAR_RESET = CH_AT;

    // Output queue sizing
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = 2;
    localparam int CNT_W      = 3;

    typedef enum logic [2:0] {
        MODE_NORMAL  = 3'd0,
        MODE_STRING  = 3'd1,
        MODE_LINE    = 3'd2,
        MODE_BLOCK   = 3'd3,
        MODE_STOPPED = 3'd4
    } scan_mode_t;

    // Scanner state carried from one decided byte to the next
    typedef struct packed {
        scan_mode_t mode;
        logic [7:0] quote_byte;
        logic [7:0] prev_out;
        logic       tail_pending;
        logic       tail_blank;
    } scan_state_t;

    localparam scan_state_t SCAN_RESET = '{
        mode:         MODE_NORMAL,
        quote_byte:   8'h00,
        prev_out:     8'h00,
        tail_pending: 1'b0,
        tail_blank:   1'b0
    };

    typedef struct packed {
        scan_state_t st;
        logic [7:0]  res;
    } decision_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } out_entry_t;

    // Decide the output for cur with nxt as lookahead, and the state after it
    function automatic decision_t decide(scan_state_t st, logic [7:0] cur,
                                         logic [7:0] nxt, logic [7:0] line_char);
        decision_t d;
        d.st  = st;
        d.res = cur;
        priority if (st.tail_pending) begin
            // second byte of a recognized pair
            d.st.tail_pending = 1'b0;
            d.res             = st.tail_blank ? CH_SPACE : cur;
            d.st.tail_blank   = 1'b0;
        end else if (st.mode == MODE_STOPPED) begin
            d.res = cur;
        end else if (cur == CH_NUL) begin
            d.st.mode = MODE_STOPPED;
        end else if (st.mode == MODE_STRING) begin
            if (cur == CH_BSLASH && nxt == st.quote_byte) begin
                d.st.tail_pending = 1'b1;
                d.st.tail_blank   = 1'b0;
            end else if (cur == st.quote_byte) begin
                d.st.mode = MODE_NORMAL;
            end
        end else if (st.mode == MODE_BLOCK) begin
            if (cur == CH_STAR && nxt == CH_SLASH) begin
                d.st.tail_pending = 1'b1;
                d.st.tail_blank   = 1'b1;
                d.st.mode         = MODE_NORMAL;
                d.res             = CH_SPACE;
            end else begin
                d.res = (cur == CH_NL) ? CH_NL : CH_SPACE;
            end
        end else if (st.mode == MODE_LINE && cur != CH_NL) begin
            d.res = CH_SPACE;
        end else begin
            // normal text, or the newline that closes a line comment
            d.st.mode = MODE_NORMAL;
            if (cur == line_char && cur != CH_NL && st.prev_out != CH_BSLASH) begin
                d.st.mode = MODE_LINE;
                d.res     = CH_SPACE;
            end else if (cur == CH_SLASH && nxt == CH_STAR) begin
                d.st.tail_pending = 1'b1;
                d.st.tail_blank   = 1'b1;
                d.st.mode         = MODE_BLOCK;
                d.res             = CH_SPACE;
            end else if (cur == CH_DQUOTE || cur == CH_SQUOTE) begin
                d.st.mode       = MODE_STRING;
                d.st.quote_byte = cur;
            end
        end
        d.st.prev_out = d.res;
        return d;
    endfunction

endpackage

/* rtl/core/asm_comment_stripper.sv */
// ============================================================================
// asm_comment_stripper
// Stream filter that blanks line and block comments in assembler text.
// ============================================================================
// One byte enters per clock while s_tready is high and one leaves while
// m_tready is high. Each output byte lags its input by one byte, as the held
// byte is decided with the next one as lookahead. A byte marked tlast
// flushes the held byte too, so that item yields two output items. A
// four-entry output queue separates the two sides: s_tready stays high, also
// with a stalled sink, while at least two entries are free. The user writes
// the comment character through the cfg channel (reset value at sign) only
// while the stream is idle; the block does not enforce this.
`timescale 1ns / 1ps

module asm_comment_stripper (
    input  logic       aclk,
    input  logic       aresetn,
    // configuration write: line comment character
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,
    // input stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // last_byte
    // result stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast    // out_last
);

    logic [7:0]          line_char_reg;
    acs_pkg::scan_state_t st_reg, st_next;
    logic [7:0]          held_reg, held_next;
    logic                held_valid_reg, held_valid_next;

    acs_pkg::out_entry_t fifo_reg [acs_pkg::FIFO_DEPTH];
    logic [acs_pkg::PTR_W-1:0] rd_ptr_reg, wr_ptr_reg;
    logic [acs_pkg::CNT_W-1:0] count_reg, count_next;

    acs_pkg::decision_t  dec_held, dec_new;
    acs_pkg::scan_state_t st_mid;
    acs_pkg::out_entry_t ent0, ent1;
    logic [1:0]          push_cnt;
    logic                in_fire, out_fire;

    assign cfg_ready = 1'b1;
    assign s_tready  = (count_reg <= acs_pkg::CNT_W'(acs_pkg::FIFO_DEPTH - 2));
    assign in_fire   = s_tvalid && s_tready;
    assign m_tvalid  = (count_reg != '0);
    assign out_fire  = m_tvalid && m_tready;
    assign m_tdata   = fifo_reg[rd_ptr_reg].data;
    assign m_tlast   = fifo_reg[rd_ptr_reg].last;

    // Decide the held byte, then the new byte when it ends the buffer
    always_comb begin
        dec_held = acs_pkg::decide(st_reg, held_reg, s_tdata, line_char_reg);
        st_mid   = held_valid_reg ? dec_held.st : st_reg;
        dec_new  = acs_pkg::decide(st_mid, s_tdata, acs_pkg::CH_NUL, line_char_reg);

        st_next         = st_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        push_cnt        = 2'd0;
        ent0            = '{data: dec_held.res, last: 1'b0};
        ent1            = '{data: dec_new.res, last: 1'b1};
        if (in_fire) begin
            if (s_tlast) begin
                st_next         = acs_pkg::SCAN_RESET;
                held_next       = 8'h00;
                held_valid_next = 1'b0;
                push_cnt        = held_valid_reg ? 2'd2 : 2'd1;
                if (!held_valid_reg) begin
                    ent0 = ent1;
                end
            end else begin
                st_next         = st_mid;
                held_next       = s_tdata;
                held_valid_next = 1'b1;
                push_cnt        = held_valid_reg ? 2'd1 : 2'd0;
            end
        end
        count_next = count_reg + acs_pkg::CNT_W'(push_cnt)
                   - acs_pkg::CNT_W'(out_fire);
    end

    // Hold scanner state, config register and queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_char_reg  <= acs_pkg::LINE_CHAR_RESET;
            st_reg         <= acs_pkg::SCAN_RESET;
            held_reg       <= 8'h00;
            held_valid_reg <= 1'b0;
            rd_ptr_reg     <= '0;
            wr_ptr_reg     <= '0;
            count_reg      <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                line_char_reg <= cfg_data;
            end
            st_reg         <= st_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            rd_ptr_reg     <= rd_ptr_reg + acs_pkg::PTR_W'(out_fire);
            wr_ptr_reg     <= wr_ptr_reg + acs_pkg::PTR_W'(push_cnt);
            count_reg      <= count_next;
        end
    end

    // Write result items into the output queue
    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            fifo_reg[wr_ptr_reg] <= ent0;
        end
        if (push_cnt == 2'd2) begin
            fifo_reg[wr_ptr_reg + acs_pkg::PTR_W'(1)] <= ent1;
        end
    end

endmodule

/* rtl/core/asm_cs_checker.sv */
// ============================================================================
// asm_cs_checker
// Port-level checks of the comment stripper, bound to the top level.
// ============================================================================
`timescale 1ns / 1ps
`include "asm_comment_stripper_defines.svh"

module asm_cs_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // A stalled result item holds its value
    `ACS_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result item changed")

    // Reset empties the output queue
    `ACS_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

    // A buffer end always leaves a result item waiting
    `ACS_ASSERT(a_last_flush, aclk, aresetn, s_tvalid && s_tready && s_tlast |=> m_tvalid, "buffer end produced no result item")

    // Input backpressure only while results wait
    `ACS_ASSERT(a_stall_cause, aclk, aresetn, !s_tready |-> m_tvalid, "input stalled with empty queue")

endmodule

bind asm_comment_stripper asm_cs_checker u_asm_cs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
